>>> rtl/trs_model_matrix_builder_assert.svh
// Assertion macros for the TRS model matrix builder.
// Used by the top level; no other dependencies.
`ifndef TRS_MODEL_MATRIX_BUILDER_ASSERT_SVH
`define TRS_MODEL_MATRIX_BUILDER_ASSERT_SVH

// Check that a condition implies a consequence on the next clock edge.
`define TMB_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the same clock edge.
`define TMB_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/tmb_pkg.sv
// Package for the TRS model matrix builder: constants, CORDIC arctangent table,
// and the arithmetic helpers shared by the pipeline modules. No dependencies.
package tmb_pkg;

    localparam int CORDIC_STAGES = 18;
    localparam int FRAC_BITS     = 16;
    localparam int TAB_LEN       = 30;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [25:0] DEG2RAD_Q30     = 26'sd18740330;

    localparam logic signed [40:0] FULL_DEG    = 41'sd360 <<< FRAC_BITS;
    localparam logic signed [40:0] HALF_DEG    = 41'sd180 <<< FRAC_BITS;
    localparam logic signed [40:0] QUARTER_DEG = 41'sd90 <<< FRAC_BITS;

    // floor(2^RECIP_SHIFT / FULL_DEG); the turn estimate is off by at most one
    localparam int                 RECIP_SHIFT = 40;
    localparam logic signed [17:0] RECIP_DEG   = 18'sd46603;

    // One CORDIC angle path: cosine, sine and residual angle, all Q30
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg_cos;
    } cordic_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] r;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            default: r = (i < TAB_LEN) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return r;
    endfunction

    // (a*b + 2^29) >> 30 with floor on Q30 operands
    function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
        return 34'(p >>> 30);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > 67'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -67'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> rtl/tmb_trig.sv
// Angle reduction and pipelined CORDIC for one Euler angle.
// Depends on tmb_pkg. The pipeline advances on en.
module tmb_trig (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] deg,
    output logic signed [33:0] cos_q30,
    output logic signed [33:0] sin_q30
);
    import tmb_pkg::*;

    logic signed [31:0] deg_reg;
    logic signed [8:0]  quo_reg, quo_next;
    logic signed [49:0] qprod;
    logic signed [40:0] red_reg, red_next;
    logic signed [40:0] fold_reg, fold_next;
    logic               negc_reg, negc_next;
    logic signed [66:0] prod;
    logic signed [66:0] mag;
    logic signed [33:0] rad_next;
    cordic_t            cor_reg [CORDIC_STAGES+1];
    cordic_t            cor_next [CORDIC_STAGES];

    // Estimate the nearest whole number of turns by reciprocal multiplication
    always_comb
    begin
        qprod    = 50'(deg) * 50'(RECIP_DEG);
        quo_next = 9'((qprod + (50'sd1 <<< (RECIP_SHIFT - 1))) >>> RECIP_SHIFT);
    end

    // Remove the turns into [-180, 180) and fix an estimate that is off by one
    always_comb
    begin
        logic signed [40:0] a;
        a = 41'(deg_reg) - 41'(quo_reg) * FULL_DEG;
        if (a < -HALF_DEG)
            a = a + FULL_DEG;
        else if (a >= HALF_DEG)
            a = a - FULL_DEG;
        red_next = a;
    end

    // Fold into [-90, 90] and flag the cosine sign
    always_comb
    begin
        fold_next = red_reg;
        negc_next = 1'b0;
        if (red_reg > QUARTER_DEG)
        begin
            fold_next = HALF_DEG - red_reg;
            negc_next = 1'b1;
        end
        else if (red_reg < -QUARTER_DEG)
        begin
            fold_next = -HALF_DEG - red_reg;
            negc_next = 1'b1;
        end
    end

    // Degrees to Q30 radians, rounded half away from zero
    always_comb
    begin
        prod = 67'(fold_reg) * 67'(DEG2RAD_Q30);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        rad_next = (prod < 0) ? -34'(mag) : 34'(mag);
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_comb
        begin
            logic signed [33:0] dx, dy;
            dx = cor_reg[i].y >>> i;
            dy = cor_reg[i].x >>> i;
            cor_next[i] = cor_reg[i];
            if (cor_reg[i].z >= 0)
            begin
                cor_next[i].x = cor_reg[i].x - dx;
                cor_next[i].y = cor_reg[i].y + dy;
                cor_next[i].z = cor_reg[i].z - atan_q30(i);
            end
            else
            begin
                cor_next[i].x = cor_reg[i].x + dx;
                cor_next[i].y = cor_reg[i].y - dy;
                cor_next[i].z = cor_reg[i].z + atan_q30(i);
            end
        end
    end

    // Advance the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg  <= deg;
            quo_reg  <= quo_next;
            red_reg  <= red_next;
            fold_reg <= fold_next;
            negc_reg <= negc_next;
            cor_reg[0].x       <= 34'(CORDIC_GAIN_Q30);
            cor_reg[0].y       <= '0;
            cor_reg[0].z       <= rad_next;
            cor_reg[0].neg_cos <= negc_reg;
            for (int i = 0; i < CORDIC_STAGES; i++)
                cor_reg[i+1] <= cor_next[i];
        end
    end

    assign cos_q30 = cor_reg[CORDIC_STAGES].neg_cos ? -cor_reg[CORDIC_STAGES].x
                                                    : cor_reg[CORDIC_STAGES].x;
    assign sin_q30 = cor_reg[CORDIC_STAGES].y;

endmodule

>>> rtl/trs_model_matrix_builder.sv
// Top level of the TRS model matrix builder: three trig pipelines, matrix
// product stages and scale stage. Depends on tmb_pkg, tmb_trig.
//
//  channel | dir | fields (tdata, low bit first)
//  s_axis  | in  | pos_x pos_y pos_z rot_x_deg rot_y_deg rot_z_deg scale_x..z
//  m_axis  | out | m00 m10 m20 m01 m11 m21 m02 m12 m22 t_x t_y t_z
//
// One item per cycle while the output is not stalled; the latency is set by the angle
// reduction, the CORDIC chain and three multiply stages. The whole pipeline
// advances when the output register is empty or taken; otherwise it holds and
// s_axis_tready drops in the same cycle as m_axis_tready.
// Reset clears the valid bits only.
module trs_model_matrix_builder (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, rot_x_deg, rot_y_deg, rot_z_deg, scale_x, scale_y, scale_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // m00, m10, m20, m01, m11, m21, m02, m12, m22, t_x, t_y, t_z
    output logic [383:0] m_axis_tdata
);
    import tmb_pkg::*;

    localparam int LAT = CORDIC_STAGES + 4;
    localparam int DEPTH = LAT + 3;

    logic               en;
    logic [DEPTH-2:0]   vld_reg;
    logic signed [31:0] dly_reg [LAT][6];
    logic signed [33:0] c [3];
    logic signed [33:0] s [3];

    // Pipeline advances unless the final stage is full and blocked
    logic out_vld_reg;
    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_trig
        tmb_trig u_trig (
            .clk     (clk),
            .en      (en),
            .deg     (s_axis_tdata[96+32*k +: 32]),
            .cos_q30 (c[k]),
            .sin_q30 (s[k])
        );
    end

    // Carry position and scale alongside the trig pipelines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dly_reg[0][j]   <= s_axis_tdata[32*j +: 32];
                dly_reg[0][j+3] <= s_axis_tdata[192+32*j +: 32];
            end
            for (int i = 1; i < LAT; i++)
                dly_reg[i] <= dly_reg[i-1];
        end
    end

    // Stage A: pairwise trig products
    logic signed [33:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, sy_reg, sxcy_reg;
    logic signed [33:0] cxcy_reg, cx_reg, sx_reg, cz_reg, sz_reg;
    logic signed [31:0] ka_reg [6];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sxsy_reg <= mul_q30(s[0], s[1]);
            cxsy_reg <= mul_q30(c[0], s[1]);
            cycz_reg <= mul_q30(c[1], c[2]);
            cysz_reg <= mul_q30(c[1], s[2]);
            sxcy_reg <= mul_q30(s[0], c[1]);
            cxcy_reg <= mul_q30(c[0], c[1]);
            sy_reg <= s[1];
            cx_reg <= c[0];
            sx_reg <= s[0];
            cz_reg <= c[2];
            sz_reg <= s[2];
            ka_reg <= dly_reg[LAT-1];
        end
    end

    // Stage B: rotation entries
    logic signed [34:0] r_reg [9];
    logic signed [31:0] kb_reg [6];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= 35'(cycz_reg);
            r_reg[1] <= 35'(mul_q30(sxsy_reg, cz_reg)) + 35'(mul_q30(cx_reg, sz_reg));
            r_reg[2] <= 35'(mul_q30(sx_reg, sz_reg)) - 35'(mul_q30(cxsy_reg, cz_reg));
            r_reg[3] <= -35'(cysz_reg);
            r_reg[4] <= 35'(mul_q30(cx_reg, cz_reg)) - 35'(mul_q30(sxsy_reg, sz_reg));
            r_reg[5] <= 35'(mul_q30(cxsy_reg, sz_reg)) + 35'(mul_q30(sx_reg, cz_reg));
            r_reg[6] <= 35'(sy_reg);
            r_reg[7] <= -35'(sxcy_reg);
            r_reg[8] <= 35'(cxcy_reg);
            kb_reg <= ka_reg;
        end
    end

    // Stage C: scale, round, saturate into the output register
    logic [383:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 9; e++)
                out_reg[32*e +: 32] <= sat32(67'((68'(r_reg[e]) * 68'(kb_reg[3 + e/3])
                                               + (68'sd1 <<< 29)) >>> 30));
            for (int j = 0; j < 3; j++)
                out_reg[288+32*j +: 32] <= kb_reg[j];
        end
    end
    assign m_axis_tdata = out_reg;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[DEPTH-3:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[DEPTH-2];
        end
    end

`include "trs_model_matrix_builder_assert.svh"

    `TMB_ASSERT_NOW(a_ready_when_empty, !out_vld_reg, s_axis_tready, "stall with empty output")
    `TMB_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output lost on stall")
    `TMB_ASSERT_NEXT(a_pipe_freeze, !en, $stable(vld_reg), "pipeline moved during stall")

endmodule

>>> test/trs_model_matrix_builder_tb.sv
// Testbench for trs_model_matrix_builder: drives position, Euler angle and scale
// items and checks each emitted 3x4 model matrix against an in-bench predictor
// or a typed-in result. Depends on tmb_pkg and the RTL top level only.
module trs_model_matrix_builder_tb;
    import tmb_pkg::*;

    localparam int  LATENCY     = CORDIC_STAGES + 7;
    localparam int  N_RANDOM    = 1000;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_DIRECTED  = 20;
    localparam int  HOLD_OFF_LEN = 200;

    typedef logic signed [31:0] q16_t;

    typedef struct packed {
        q16_t scale_z, scale_y, scale_x;
        q16_t rot_z, rot_y, rot_x;
        q16_t pos_z, pos_y, pos_x;
    } pose_t;

    typedef struct packed {
        q16_t t_z, t_y, t_x;
        q16_t m22, m12, m02;
        q16_t m21, m11, m01;
        q16_t m20, m10, m00;
    } matrix_t;

    typedef struct {
        pose_t   pose;
        logic    fixed;
        matrix_t mat;
    } pose_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pos_x, pos_y, pos_z, rot_x_deg, rot_y_deg, rot_z_deg, scale_x, scale_y, scale_z
    logic [287:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // m00, m10, m20, m01, m11, m21, m02, m12, m22, t_x, t_y, t_z
    logic [383:0] m_axis_tdata;

    matrix_t   matrix_queue[$];
    pose_row_t pose_table[N_DIRECTED];
    int        n_errors = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off_cycles = 0;
    logic      hold_off_req = 1'b0;
    logic      sending_done = 1'b0;

    trs_model_matrix_builder u_top (.*);

    always #6 clk = ~clk;

    // Cosine and sine of an angle in degrees, Q30
    task automatic angle_trig(input q16_t deg, output longint c, output longint s);
        longint a, prod, rad, x, y, z, dx, dy;
        logic   neg_cos;
        a = longint'(deg) % (longint'(360) <<< FRAC_BITS);
        neg_cos = 1'b0;
        if (a < 0) a += longint'(360) <<< FRAC_BITS;
        if (a >= (longint'(180) <<< FRAC_BITS)) a -= longint'(360) <<< FRAC_BITS;
        if (a > (longint'(90) <<< FRAC_BITS))
        begin
            a = (longint'(180) <<< FRAC_BITS) - a;
            neg_cos = 1'b1;
        end
        else if (a < -(longint'(90) <<< FRAC_BITS))
        begin
            a = -(longint'(180) <<< FRAC_BITS) - a;
            neg_cos = 1'b1;
        end
        prod = a * 64'sd18740330;
        if (prod >= 0) rad = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        else rad = -((-prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        x = 64'sd652032874;
        y = 0;
        z = rad;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_q30(i);
            end
            else
            begin
                x += dx; y -= dy; z += arctan_q30(i);
            end
        end
        c = neg_cos ? -x : x;
        s = y;
    endtask

    function automatic longint arctan_q30(input int i);
        longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        return (i < 10) ? tbl[i] : (64'sd1 <<< (30 - i));
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Scale one rotation entry into Q16.16 and saturate
    function automatic q16_t scale_entry(input longint e, input q16_t k);
        logic signed [127:0] p;
        p = (128'(signed'(e)) * 128'(signed'(k)) + (128'sd1 <<< 29)) >>> 30;
        if (p > 128'sd2147483647) return 32'sh7fffffff;
        if (p < -128'sd2147483648) return 32'sh80000000;
        return p[31:0];
    endfunction

    task automatic build_matrix(input pose_t p, output matrix_t m);
        longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
        angle_trig(p.rot_x, cx, sx);
        angle_trig(p.rot_y, cy, sy);
        angle_trig(p.rot_z, cz, sz);
        sxsy = q30_product(sx, sy);
        cxsy = q30_product(cx, sy);
        m.m00 = scale_entry(q30_product(cy, cz), p.scale_x);
        m.m10 = scale_entry(q30_product(sxsy, cz) + q30_product(cx, sz), p.scale_x);
        m.m20 = scale_entry(-q30_product(cxsy, cz) + q30_product(sx, sz), p.scale_x);
        m.m01 = scale_entry(-q30_product(cy, sz), p.scale_y);
        m.m11 = scale_entry(-q30_product(sxsy, sz) + q30_product(cx, cz), p.scale_y);
        m.m21 = scale_entry(q30_product(cxsy, sz) + q30_product(sx, cz), p.scale_y);
        m.m02 = scale_entry(sy, p.scale_z);
        m.m12 = scale_entry(-q30_product(sx, cy), p.scale_z);
        m.m22 = scale_entry(q30_product(cx, cy), p.scale_z);
        m.t_x = p.pos_x;
        m.t_y = p.pos_y;
        m.t_z = p.pos_z;
    endtask

    task automatic report_mismatch(input string what, input q16_t got, input q16_t want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        n_errors++;
    endtask

    function automatic q16_t random_angle();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return q16_t'($urandom_range(0, 720 << 16)) - (360 << 16);
            2: return q16_t'($urandom_range(0, 8) * (45 << 16)) + q16_t'($urandom_range(0, 3)) - 1;
            default: return q16_t'($urandom_range(0, 400 << 16)) - (200 << 16);
        endcase
    endfunction

    function automatic q16_t random_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return q16_t'($urandom_range(0, 8 << 16)) - (4 << 16);
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return q16_t'($urandom_range(0, 2 << 16));
        endcase
    endfunction

    // Fill the directed rows; the zero-scale ones carry a typed-in result
    task automatic fill_table();
        pose_t   p;
        matrix_t m;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            p = '{default: 32'sh0};
            pose_table[i].fixed = 1'b0;
            pose_table[i].mat = '0;
            case (i)
                0:  ;
                1:  p = '{default: 32'sh7fffffff};
                2:  p = '{default: 32'sh80000000};
                3:  begin p.rot_x = 90 << 16; p.scale_x = 1 << 16; p.scale_y = 1 << 16;
                          p.scale_z = 1 << 16; end
                4:  begin p.rot_y = 180 << 16; p.scale_x = 1 << 16; p.scale_y = 1 << 16;
                          p.scale_z = 1 << 16; end
                5:  begin p.rot_z = -(90 << 16); p.scale_x = 1 << 16; p.scale_y = 1 << 16;
                          p.scale_z = 1 << 16; end
                6:  begin p.rot_x = 32'sh7fffffff; p.rot_y = 32'sh80000000;
                          p.rot_z = 360 << 16; p.scale_x = 32'sh7fffffff;
                          p.scale_y = 32'sh80000000; p.scale_z = 32'sh7fffffff; end
                7:  begin p.rot_x = (90 << 16) + 1; p.rot_y = -(90 << 16) - 1;
                          p.rot_z = 180 << 16; p.scale_x = 32'sh7fffffff;
                          p.scale_y = 32'sh7fffffff; p.scale_z = 32'sh80000000; end
                8:  begin p.rot_x = 45 << 16; p.rot_y = 30 << 16; p.rot_z = 60 << 16;
                          p.scale_x = 2 << 16; p.scale_y = 3 << 16; p.scale_z = -(1 << 16); end
                default:
                begin
                    p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
                    p.rot_x = random_angle(); p.rot_y = random_angle(); p.rot_z = random_angle();
                    p.scale_x = random_value(); p.scale_y = random_value();
                    p.scale_z = random_value();
                end
            endcase
            pose_table[i].pose = p;
        end
        // Zero scale gives an all-zero rotation part and a pass-through position
        pose_table[0].fixed = 1'b1;
        pose_table[1].fixed = 1'b1;
        m = '0;
        m.t_x = 32'sh7fffffff; m.t_y = 32'sh7fffffff; m.t_z = 32'sh7fffffff;
        pose_table[1].pose.scale_x = 0; pose_table[1].pose.scale_y = 0;
        pose_table[1].pose.scale_z = 0;
        pose_table[1].mat = m;
    endtask

    // Offer one item and wait for its acceptance; drop valid only while idling
    task automatic send_pose(input pose_t p);
        while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_checked(input pose_t p);
        matrix_t m;
        build_matrix(p, m);
        matrix_queue.push_back(m);
        send_pose(p);
    endtask

    // Stimulus: directed table, then random phases with varied idling
    initial
    begin
        pose_t p;
        fill_table();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (pose_table[i].fixed)
            begin
                matrix_queue.push_back(pose_table[i].mat);
                send_pose(pose_table[i].pose);
            end
            else
                send_checked(pose_table[i].pose);
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case (i / 200)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                3: begin send_idle_pct = 34; recv_stall_pct = 34; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (i == 850) hold_off_req = 1'b1;
            p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
            p.rot_x = random_angle(); p.rot_y = random_angle(); p.rot_z = random_angle();
            p.scale_x = random_value(); p.scale_y = random_value(); p.scale_z = random_value();
            send_checked(p);
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (hold_off_req && hold_off_cycles < HOLD_OFF_LEN)
        begin
            hold_off_cycles <= hold_off_cycles + 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end

    // Check each accepted matrix against the oldest prediction
    always @(posedge clk)
    begin
        matrix_t got;
        matrix_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (matrix_queue.size() == 0)
            begin
                $display("unexpected matrix %h", m_axis_tdata);
                n_errors++;
            end
            else
            begin
                want = matrix_queue.pop_front();
                if (got.m00 !== want.m00) report_mismatch("m00", got.m00, want.m00);
                if (got.m10 !== want.m10) report_mismatch("m10", got.m10, want.m10);
                if (got.m20 !== want.m20) report_mismatch("m20", got.m20, want.m20);
                if (got.m01 !== want.m01) report_mismatch("m01", got.m01, want.m01);
                if (got.m11 !== want.m11) report_mismatch("m11", got.m11, want.m11);
                if (got.m21 !== want.m21) report_mismatch("m21", got.m21, want.m21);
                if (got.m02 !== want.m02) report_mismatch("m02", got.m02, want.m02);
                if (got.m12 !== want.m12) report_mismatch("m12", got.m12, want.m12);
                if (got.m22 !== want.m22) report_mismatch("m22", got.m22, want.m22);
                if (got.t_x !== want.t_x) report_mismatch("t_x", got.t_x, want.t_x);
                if (got.t_y !== want.t_y) report_mismatch("t_y", got.t_y, want.t_y);
                if (got.t_z !== want.t_z) report_mismatch("t_z", got.t_z, want.t_z);
            end
        end
    end

    // End of run: drain, settle, then report; timeout on the cycle limit
    initial
    begin
        wait (sending_done && matrix_queue.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end
endmodule
